// ===== rtl/hzcd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hzcd_pkg
// Shared types and codes for the hysteresis zero-crossing detector.
// ----------------------------------------------------------------------------
package hzcd_pkg;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HYSTERESIS  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIRECTION   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EVENT_LIMIT = 2'd3;

  localparam logic [1:0] DIR_RISING  = 2'd0;
  localparam logic [1:0] DIR_FALLING = 2'd1;
  localparam logic [1:0] DIR_BOTH    = 2'd2;

  localparam logic [1:0]  DIR_MODE_RESET    = DIR_BOTH;
  localparam logic [15:0] EVENT_LIMIT_RESET = 16'd64;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_CROSS  = 2'd1;
  localparam logic [1:0] ST_TOO_FEW   = 2'd2;
  localparam logic [1:0] ST_LIMIT_EXC = 2'd3;

  localparam logic KIND_EVENT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic EDGE_RISE = 1'b0;
  localparam logic EDGE_FALL = 1'b1;

  localparam int OQ_DEPTH    = 4;
  localparam int OQ_PTR_BITS = 2;
  localparam int OQ_CNT_BITS = 3;

  typedef struct packed {
    logic        kind;
    logic [15:0] index;
    logic        direction;
    logic [15:0] event_total;
    logic [15:0] rising_total;
    logic [15:0] falling_total;
    logic [1:0]  status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } push_t;

endpackage : hzcd_pkg
`default_nettype wire

// ===== rtl/hysteresis_zero_cross_detector_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hysteresis_zero_cross_detector_unit
// Zero-crossing detector with hysteresis over buffers of signed samples.
// ----------------------------------------------------------------------------
// One sample is taken per cycle while in_stall is low. It lands in an input
// register, is evaluated in the next cycle and its results (a crossing event,
// an end-of-buffer summary, or both) enter a four-entry result queue, from
// whose head they are visible once written. The result port moves one result
// per cycle while out_stall is low, so a sample that yields both an event and
// a summary needs two output transfers; the input stalls when the queue,
// counting the results of the sample now being evaluated and ignoring a result
// leaving in the same cycle, has fewer than two free entries.
// ----------------------------------------------------------------------------
module hysteresis_zero_cross_detector_unit
  import hzcd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  signed [SAMPLE_BITS-1:0]   in_sample,
  input  wire                             in_last_sample,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            out_result_kind,
  output logic        [15:0]              out_sample_index,
  output logic                            out_edge_direction,
  output logic        [15:0]              out_event_total,
  output logic        [15:0]              out_rising_total,
  output logic        [15:0]              out_falling_total,
  output logic        [1:0]               out_status,
  output logic                            out_last_result,
  input  wire                             cfg_wr_en,
  input  wire         [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire         [CFG_DATA_BITS-1:0] cfg_data
);

  push_t                  push;
  result_t                head;
  logic [OQ_CNT_BITS-1:0] count;
  logic                   take;
  logic                   pop;
  logic [OQ_CNT_BITS:0]   fill;

  assign fill     = (OQ_CNT_BITS + 1)'(count) + (OQ_CNT_BITS + 1)'(push.cnt);
  assign in_stall = fill > (OQ_CNT_BITS + 1)'(OQ_DEPTH - 2);
  assign take     = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  hzcd_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .sample     (in_sample),
    .last_sample(in_last_sample),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push)
  );

  hzcd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .not_empty(out_valid),
    .head     (head),
    .count    (count)
  );

  assign out_result_kind    = head.kind;
  assign out_sample_index   = head.index;
  assign out_edge_direction = head.direction;
  assign out_event_total    = head.event_total;
  assign out_rising_total   = head.rising_total;
  assign out_falling_total  = head.falling_total;
  assign out_status         = head.status;
  assign out_last_result    = head.last;

endmodule : hysteresis_zero_cross_detector_unit
`default_nettype wire

// ===== rtl/hzcd_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hzcd_core
// Input register, configuration registers and the per-sample crossing logic.
// ----------------------------------------------------------------------------
module hzcd_core
  import hzcd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            take,
  input  wire  signed [SAMPLE_BITS-1:0]  sample,
  input  wire                            last_sample,
  input  wire                            cfg_wr_en,
  input  wire         [CFG_IDX_BITS-1:0] cfg_index,
  input  wire         [CFG_DATA_BITS-1:0] cfg_data,
  output push_t                          push
);

  localparam int WIDE     = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int CMP_BITS = WIDE + 2;
  localparam int IDX_EXT  = (INDEX_BITS > 16) ? INDEX_BITS : 16;

  logic signed [15:0] thr_r;
  logic        [14:0] hyst_r;
  logic        [1:0]  dir_r;
  logic        [15:0] lim_r;

  logic                          s_valid_r;
  logic signed [SAMPLE_BITS-1:0] s_sample_r;
  logic                          s_last_r;

  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic                          have_prev_r, have_prev_nxt;
  logic                          rarm_r, rarm_nxt;
  logic                          farm_r, farm_nxt;
  logic        [INDEX_BITS-1:0]  idx_r, idx_nxt;
  logic        [15:0]            ev_r, ev_nxt;
  logic        [15:0]            ri_r, ri_nxt;
  logic        [15:0]            fa_r, fa_nxt;
  logic                          lim_exc_r, lim_exc_nxt;

  logic signed [CMP_BITS-1:0] cur_x, prev_x, thr_x, lower_x, upper_x;
  logic                       rise_en, fall_en, rise_hit, fall_hit, hit, emit, at_limit;
  logic [IDX_EXT-1:0]         idx_ext;
  result_t                    ev_res, sum_res;
  logic [1:0]                 st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= '0;
      hyst_r <= '0;
      dir_r  <= DIR_MODE_RESET;
      lim_r  <= EVENT_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_THRESHOLD:   thr_r  <= $signed(cfg_data);
        CFG_HYSTERESIS:  hyst_r <= cfg_data[14:0];
        CFG_DIRECTION:   dir_r  <= cfg_data[1:0];
        CFG_EVENT_LIMIT: lim_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= take;
    end
    if (take) begin
      s_sample_r <= sample;
      s_last_r   <= last_sample;
    end
  end

  always_comb begin
    cur_x   = CMP_BITS'(s_sample_r);
    prev_x  = CMP_BITS'(prev_r);
    thr_x   = CMP_BITS'(thr_r);
    lower_x = thr_x - $signed(CMP_BITS'(hyst_r));
    upper_x = thr_x + $signed(CMP_BITS'(hyst_r));
    rise_en = (dir_r == DIR_RISING) || (dir_r == DIR_BOTH);
    fall_en = (dir_r == DIR_FALLING) || (dir_r == DIR_BOTH);

    rise_hit = have_prev_r && rise_en && rarm_r && (prev_x < thr_x) && (cur_x >= thr_x);
    fall_hit = have_prev_r && fall_en && farm_r && (prev_x > thr_x) && (cur_x <= thr_x);
    hit      = rise_hit || fall_hit;
    at_limit = ev_r >= lim_r;
    emit     = hit && !lim_exc_r && !at_limit;

    prev_nxt      = s_sample_r;
    have_prev_nxt = 1'b1;
    ev_nxt        = emit ? ev_r + 16'd1 : ev_r;
    ri_nxt        = (emit && rise_hit) ? ri_r + 16'd1 : ri_r;
    fa_nxt        = (emit && fall_hit) ? fa_r + 16'd1 : fa_r;
    lim_exc_nxt   = lim_exc_r || (hit && at_limit);

    if (!have_prev_r) begin
      idx_nxt  = '0;
      rarm_nxt = cur_x <= lower_x;
      farm_nxt = cur_x >= upper_x;
    end else begin
      idx_nxt  = (idx_r != {INDEX_BITS{1'b1}}) ? idx_r + 1'b1 : idx_r;
      rarm_nxt = (rarm_r && !rise_hit) || (cur_x <= lower_x);
      farm_nxt = (farm_r && !fall_hit) || (cur_x >= upper_x);
    end

    idx_ext = IDX_EXT'(idx_nxt);

    if (!have_prev_r) begin
      st = ST_TOO_FEW;
    end else if (lim_exc_nxt) begin
      st = ST_LIMIT_EXC;
    end else if (ev_nxt == 16'd0) begin
      st = ST_NO_CROSS;
    end else begin
      st = ST_OK;
    end

    ev_res               = '0;
    ev_res.kind          = KIND_EVENT;
    ev_res.index         = idx_ext[15:0];
    ev_res.direction     = fall_hit ? EDGE_FALL : EDGE_RISE;
    ev_res.last          = !s_last_r;

    sum_res               = '0;
    sum_res.kind          = KIND_SUMMARY;
    sum_res.index         = idx_ext[15:0];
    sum_res.event_total   = ev_nxt;
    sum_res.rising_total  = ri_nxt;
    sum_res.falling_total = fa_nxt;
    sum_res.status        = st;
    sum_res.last          = 1'b1;

    push = '0;
    if (s_valid_r) begin
      if (emit) begin
        push.first  = ev_res;
        push.second = sum_res;
        push.cnt    = s_last_r ? 2'd2 : 2'd1;
      end else if (s_last_r) begin
        push.first = sum_res;
        push.cnt   = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (s_valid_r && s_last_r)) begin
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      rarm_r      <= 1'b0;
      farm_r      <= 1'b0;
      idx_r       <= '0;
      ev_r        <= '0;
      ri_r        <= '0;
      fa_r        <= '0;
      lim_exc_r   <= 1'b0;
    end else if (s_valid_r) begin
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      rarm_r      <= rarm_nxt;
      farm_r      <= farm_nxt;
      idx_r       <= idx_nxt;
      ev_r        <= ev_nxt;
      ri_r        <= ri_nxt;
      fa_r        <= fa_nxt;
      lim_exc_r   <= lim_exc_nxt;
    end
  end

endmodule : hzcd_core
`default_nettype wire

// ===== rtl/hzcd_outq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hzcd_outq
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module hzcd_outq
  import hzcd_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire push_t             push,
  input  wire                    pop,
  output logic                   not_empty,
  output result_t                head,
  output logic [OQ_CNT_BITS-1:0] count
);

  result_t                 mem [OQ_DEPTH];
  logic [OQ_PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [OQ_CNT_BITS-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_p1  = wr_ptr_r + 1'b1;
    wr_ptr_nxt = wr_ptr_r + OQ_PTR_BITS'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + OQ_CNT_BITS'(push.cnt) - OQ_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign not_empty = cnt_r != '0;
  assign head      = mem[rd_ptr_r];
  assign count     = cnt_r;

endmodule : hzcd_outq
`default_nettype wire
